// ===== sv/periodic_laplacian_stencil_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the periodic lattice Laplacian block
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_LAPLACIAN_STENCIL_TOP_ASSERT_SVH
`define PERIODIC_LAPLACIAN_STENCIL_TOP_ASSERT_SVH

// same-cycle implication
`define PLS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// Constants, types and helper functions for the periodic lattice Laplacian.
// ----------------------------------------------------------------------------
package pls_pkg;

    // lattice storage geometry
    localparam int MAX_EXTENT  = 16;
    localparam int NUM_VOLUMES = 2;
    localparam int COORD_W     = $clog2(MAX_EXTENT);
    localparam int VOL_W       = 1;
    localparam int ADDR_W      = VOL_W + 3 * COORD_W;
    localparam int STORE_DEPTH = NUM_VOLUMES * MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;

    // datapath widths
    localparam int SAMPLE_W = 32;
    localparam int WORD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 40;
    localparam int WT_W     = 8;
    localparam int EXT_W    = 5;
    localparam int TAP_W    = 4;
    localparam int DELTA_W  = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_X_EXTENT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_EXTENT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_EXTENT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STENCIL_ORDER = 3'd3;
    localparam logic [EXT_W-1:0]     EXTENT_RESET     = 5'd16;

    // commands and stencil orders
    localparam logic CMD_WRITE      = 1'b0;
    localparam logic CMD_QUERY      = 1'b1;
    localparam logic ORDER_SEVEN    = 1'b0;
    localparam logic ORDER_THIRTEEN = 1'b1;

    // last tap index per stencil, and division steps (8 bits each)
    localparam logic [TAP_W-1:0] TAP_LAST_SEVEN    = 4'd6;
    localparam logic [TAP_W-1:0] TAP_LAST_THIRTEEN = 4'd12;
    localparam logic [TAP_W-1:0] DIV_STEPS         = 4'd5;

    // stencil weights
    localparam logic signed [WT_W-1:0] WT_CENTER_SEVEN    = -8'sd6;
    localparam logic signed [WT_W-1:0] WT_CENTER_THIRTEEN = -8'sd90;
    localparam logic signed [WT_W-1:0] WT_NEAR_SEVEN      = 8'sd1;
    localparam logic signed [WT_W-1:0] WT_NEAR_THIRTEEN   = 8'sd16;
    localparam logic signed [WT_W-1:0] WT_FAR             = -8'sd1;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [DELTA_W-1:0] dz;
    } tap_offset_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                clip;
    } sat_t;

    // register value clamped to 1..MAX_EXTENT
    function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] e);
        logic [EXT_W-1:0] r;
        r = e;
        if (e == '0) r = EXT_W'(1);
        else if (e > EXT_W'(MAX_EXTENT)) r = EXT_W'(MAX_EXTENT);
        return r;
    endfunction

    // neighbor offset for each tap: center, near ring, far ring
    function automatic tap_offset_t tap_offset(input logic [TAP_W-1:0] tap);
        tap_offset_t o;
        o = '0;
        unique case (tap)
            4'd1:    o.dx = 3'sd1;
            4'd2:    o.dx = -3'sd1;
            4'd3:    o.dy = 3'sd1;
            4'd4:    o.dy = -3'sd1;
            4'd5:    o.dz = 3'sd1;
            4'd6:    o.dz = -3'sd1;
            4'd7:    o.dx = 3'sd2;
            4'd8:    o.dx = -3'sd2;
            4'd9:    o.dy = 3'sd2;
            4'd10:   o.dy = -3'sd2;
            4'd11:   o.dz = 3'sd2;
            4'd12:   o.dz = -3'sd2;
            default: o = '0;
        endcase
        return o;
    endfunction

    // (c + d) mod e for |d| <= 2, c < e; two folds cover extents of 1 and 2
    function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                      input logic signed [DELTA_W-1:0] d,
                                                      input logic [EXT_W-1:0] e);
        logic signed [7:0] t;
        logic signed [7:0] es;
        es = signed'({3'b000, e});
        t  = signed'({4'b0000, c}) + 8'(d);
        if (t < 0) t = t + es;
        if (t < 0) t = t + es;
        if (t >= es) t = t - es;
        if (t >= es) t = t - es;
        return t[COORD_W-1:0];
    endfunction

    function automatic logic signed [WT_W-1:0] tap_weight(input logic [TAP_W-1:0] tap,
                                                         input logic order);
        logic signed [WT_W-1:0] w;
        if (tap == '0)
            w = order ? WT_CENTER_THIRTEEN : WT_CENTER_SEVEN;
        else if (tap <= TAP_LAST_SEVEN)
            w = order ? WT_NEAR_THIRTEEN : WT_NEAR_SEVEN;
        else
            w = WT_FAR;
        return w;
    endfunction

    // one byte of long division by 3: returns {remainder, quotient byte}
    function automatic logic [9:0] div3_byte(input logic [1:0] rem, input logic [7:0] b);
        logic [1:0] r;
        logic [2:0] r3;
        logic [7:0] q;
        r = rem;
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            r3 = {r, b[i]};
            if (r3 >= 3'd3) begin
                q[i] = 1'b1;
                r3   = r3 - 3'd3;
            end
            r = r3[1:0];
        end
        return {r, q};
    endfunction

    // clip a wide signed value to signed 32 bits
    function automatic sat_t sat_lane(input logic signed [ACC_W-1:0] v);
        sat_t s;
        if (v > ACC_W'(64'sh7FFF_FFFF)) begin
            s.value = 32'h7FFF_FFFF;
            s.clip  = 1'b1;
        end else if (v < -ACC_W'(64'sh8000_0000)) begin
            s.value = 32'h8000_0000;
            s.clip  = 1'b1;
        end else begin
            s.value = v[SAMPLE_W-1:0];
            s.clip  = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== sv/periodic_laplacian_stencil_top.sv =====
// ----------------------------------------------------------------------------
// periodic_laplacian_stencil_top
// Complex-sample store for small periodic 3D lattices with a 7-point or
// 13-point discrete Laplacian query, one memory read and one accumulate a cycle.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  s_        in   tuser: command; tdata: volume, site_x/y/z, sample_re, sample_im
//  m_        out  tdata: lap_re, lap_im; tuser: saturated, bad_coordinate
//  cfg_      in   register write: index, data (extents, stencil order)
//
//  Write beat: a single memory write.
//  Query: the single-port site memory (one tap a cycle) and, for the 13-point
//  stencil, the 8-bit-a-cycle divide by 12 set its length.
//  Bad coordinate query: skips the memory reads. A finished result waits
//  in the output register while the next beat is accepted; a query stalls
//  at its last cycle only if that register is still full.
//  Reset is synchronous, active low; the site memory is not cleared.
// ----------------------------------------------------------------------------
module periodic_laplacian_stencil_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [pls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pls_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [79:0]                     s_tdata,  // volume, site_x, site_y, site_z,
                                                      // sample_re, sample_im, 3'b0 pad
    input  logic                            s_tuser,  // command
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,  // lap_re, lap_im
    output logic [1:0]                      m_tuser   // saturated, bad_coordinate
);

    localparam int CW = pls_pkg::COORD_W;
    localparam int SW = pls_pkg::SAMPLE_W;
    localparam int AW = pls_pkg::ACC_W;
    localparam int EW = pls_pkg::EXT_W;
    localparam int TW = pls_pkg::TAP_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [EW-1:0] ext_x_reg, ext_y_reg, ext_z_reg;
    logic          order_reg;

    // latched query
    logic [pls_pkg::VOL_W-1:0] vol_q_reg;
    logic [CW-1:0]             x_q_reg, y_q_reg, z_q_reg;
    logic                      qorder_reg;
    logic                      bad_reg;
    logic [TW-1:0]             cnt_reg;

    // accumulators and divider
    logic signed [AW-1:0] acc_re_reg, acc_im_reg;
    logic [AW-1:0]        num_re_reg, num_im_reg;
    logic [1:0]           rem_re_reg, rem_im_reg;
    logic                 neg_re_reg, neg_im_reg;

    // output register
    logic          m_tvalid_reg;
    logic [63:0]   m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    // site memory
    logic [pls_pkg::WORD_W-1:0] site_mem [pls_pkg::STORE_DEPTH];
    logic [pls_pkg::WORD_W-1:0] rd_data_reg;

    // input beat fields
    logic                      s_cmd;
    logic [pls_pkg::VOL_W-1:0] s_vol;
    logic [CW-1:0]             s_x, s_y, s_z;
    logic [SW-1:0]             s_re, s_im;

    assign s_cmd = s_tuser;
    assign s_vol = s_tdata[0];
    assign s_x   = s_tdata[4:1];
    assign s_y   = s_tdata[8:5];
    assign s_z   = s_tdata[12:9];
    assign s_re  = s_tdata[44:13];
    assign s_im  = s_tdata[76:45];

    logic s_acc;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // effective extents and bad-coordinate check
    logic [EW-1:0] eff_x, eff_y, eff_z;
    logic          s_bad;
    assign eff_x = pls_pkg::eff_extent(ext_x_reg);
    assign eff_y = pls_pkg::eff_extent(ext_y_reg);
    assign eff_z = pls_pkg::eff_extent(ext_z_reg);
    assign s_bad = ({1'b0, s_x} >= eff_x) || ({1'b0, s_y} >= eff_y) ||
                   ({1'b0, s_z} >= eff_z);

    // tap address generation
    pls_pkg::tap_offset_t  off;
    logic [CW-1:0]         ax, ay, az;
    logic [TW-1:0]         tap_last;
    logic [pls_pkg::ADDR_W-1:0] tap_addr, mem_addr;
    logic                  mem_we, mem_re;

    assign off      = pls_pkg::tap_offset(cnt_reg);
    assign ax       = pls_pkg::wrap_coord(x_q_reg, off.dx, eff_x);
    assign ay       = pls_pkg::wrap_coord(y_q_reg, off.dy, eff_y);
    assign az       = pls_pkg::wrap_coord(z_q_reg, off.dz, eff_z);
    assign tap_addr = {vol_q_reg, az, ay, ax};
    assign tap_last = qorder_reg ? pls_pkg::TAP_LAST_THIRTEEN : pls_pkg::TAP_LAST_SEVEN;

    assign mem_we   = s_acc && (s_cmd == pls_pkg::CMD_WRITE);
    assign mem_re   = (state_reg == ST_READ) && (cnt_reg <= tap_last);
    assign mem_addr = (state_reg == ST_IDLE) ? {s_vol, s_z, s_y, s_x} : tap_addr;

    // single-port memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            site_mem[mem_addr] <= {s_im, s_re};
        end
        if (mem_re) begin
            rd_data_reg <= site_mem[mem_addr];
        end
    end

    // weighted term of the tap read last cycle
    logic signed [pls_pkg::WT_W-1:0] wt;
    logic signed [SW-1:0]            rd_re, rd_im;
    logic signed [AW-1:0]            term_re, term_im;

    assign wt      = pls_pkg::tap_weight(TW'(cnt_reg - 4'd1), qorder_reg);
    assign rd_re   = signed'(rd_data_reg[SW-1:0]);
    assign rd_im   = signed'(rd_data_reg[2*SW-1:SW]);
    assign term_re = AW'(rd_re) * AW'(wt);
    assign term_im = AW'(rd_im) * AW'(wt);

    // divider: magnitude / 4, then / 3 one byte per step
    logic [AW-1:0] mag_re, mag_im;
    logic [9:0]    dstep_re, dstep_im;

    assign mag_re   = acc_re_reg[AW-1] ? AW'(-acc_re_reg) : acc_re_reg;
    assign mag_im   = acc_im_reg[AW-1] ? AW'(-acc_im_reg) : acc_im_reg;
    assign dstep_re = pls_pkg::div3_byte(rem_re_reg, num_re_reg[AW-1 -: 8]);
    assign dstep_im = pls_pkg::div3_byte(rem_im_reg, num_im_reg[AW-1 -: 8]);

    // final lane values and saturation
    logic signed [AW-1:0] val_re, val_im;
    pls_pkg::sat_t        sat_re, sat_im;
    logic                 out_free;

    always_comb begin
        if (bad_reg) begin
            val_re = '0;
            val_im = '0;
        end else if (qorder_reg == pls_pkg::ORDER_THIRTEEN) begin
            val_re = neg_re_reg ? AW'(-signed'(num_re_reg)) : signed'(num_re_reg);
            val_im = neg_im_reg ? AW'(-signed'(num_im_reg)) : signed'(num_im_reg);
        end else begin
            val_re = acc_re_reg;
            val_im = acc_im_reg;
        end
    end

    assign sat_re   = pls_pkg::sat_lane(val_re);
    assign sat_im   = pls_pkg::sat_lane(val_im);
    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_cmd == pls_pkg::CMD_QUERY)) begin
                    state_next = s_bad ? ST_DONE : ST_READ;
                end
            end
            ST_READ: begin
                if (cnt_reg == TW'(tap_last + 4'd1)) begin
                    state_next = qorder_reg ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (cnt_reg == pls_pkg::DIV_STEPS) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ext_x_reg    <= pls_pkg::EXTENT_RESET;
            ext_y_reg    <= pls_pkg::EXTENT_RESET;
            ext_z_reg    <= pls_pkg::EXTENT_RESET;
            order_reg    <= pls_pkg::ORDER_SEVEN;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    pls_pkg::REG_X_EXTENT:      ext_x_reg <= cfg_data;
                    pls_pkg::REG_Y_EXTENT:      ext_y_reg <= cfg_data;
                    pls_pkg::REG_Z_EXTENT:      ext_z_reg <= cfg_data;
                    pls_pkg::REG_STENCIL_ORDER: order_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            // tap counter in READ, step counter in DIV
            if (state_next != state_reg) begin
                cnt_reg <= '0;
            end else if ((state_reg == ST_READ) || (state_reg == ST_DIV)) begin
                cnt_reg <= TW'(cnt_reg + 4'd1);
            end

            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc && (s_cmd == pls_pkg::CMD_QUERY)) begin
            vol_q_reg  <= s_vol;
            x_q_reg    <= s_x;
            y_q_reg    <= s_y;
            z_q_reg    <= s_z;
            qorder_reg <= order_reg;
            bad_reg    <= s_bad;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if ((state_reg == ST_READ) && (cnt_reg != '0)) begin
            acc_re_reg <= acc_re_reg + term_re;
            acc_im_reg <= acc_im_reg + term_im;
        end

        if (state_reg == ST_DIV) begin
            if (cnt_reg == '0) begin
                num_re_reg <= mag_re >> 2;
                num_im_reg <= mag_im >> 2;
                rem_re_reg <= '0;
                rem_im_reg <= '0;
                neg_re_reg <= acc_re_reg[AW-1];
                neg_im_reg <= acc_im_reg[AW-1];
            end else begin
                num_re_reg <= {num_re_reg[AW-9:0], dstep_re[7:0]};
                num_im_reg <= {num_im_reg[AW-9:0], dstep_im[7:0]};
                rem_re_reg <= dstep_re[9:8];
                rem_im_reg <= dstep_im[9:8];
            end
        end

        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= {sat_im.value, sat_re.value};
            m_tuser_reg <= {bad_reg, sat_re.clip || sat_im.clip};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
`include "periodic_laplacian_stencil_top_assert.svh"

    `PLS_ASSERT_SAME(a_bad_result_clean, m_tvalid && m_tuser[1],
        (m_tdata == '0) && !m_tuser[0], "bad-coordinate result not zero or flagged saturated")
    `PLS_ASSERT_SAME(a_tap_count_bound, state_reg == ST_READ,
        cnt_reg <= TW'(tap_last + 4'd1), "tap counter ran past the stencil")
    `PLS_ASSERT_NEXT(a_good_query_reads, s_acc && s_cmd == pls_pkg::CMD_QUERY && !s_bad,
        state_reg == ST_READ, "valid query did not start reading taps")
    `PLS_ASSERT_SAME(a_div_only_thirteen, state_reg == ST_DIV,
        qorder_reg == pls_pkg::ORDER_THIRTEEN, "divide entered for seven-point stencil")

endmodule
